>>> rtl/ncc_pkg.sv
package ncc_pkg;

    localparam int REG_COUNT   = 6;
    localparam int CHANNELS    = 3;
    localparam int INDEX_W     = 3;
    localparam int COLOR_W     = 24;
    localparam int PULSE_W     = 16;
    localparam int LEVEL_W     = 8;
    localparam int DIST_W      = 18;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 17;

    localparam int PULSE_TOP = 260;
    localparam int LO_RED    = 15;
    localparam int LO_GREEN  = 16;
    localparam int LO_BLUE   = 14;

    localparam int DIV_RED   = PULSE_TOP - LO_RED;
    localparam int DIV_GREEN = PULSE_TOP - LO_GREEN;
    localparam int DIV_BLUE  = PULSE_TOP - LO_BLUE;

    localparam int RECIP_RED   = ((1 << RECIP_SHIFT) + DIV_RED - 1) / DIV_RED;
    localparam int RECIP_GREEN = ((1 << RECIP_SHIFT) + DIV_GREEN - 1) / DIV_GREEN;
    localparam int RECIP_BLUE  = ((1 << RECIP_SHIFT) + DIV_BLUE - 1) / DIV_BLUE;

    localparam logic [PULSE_W-1:0] LO_OFFSET [CHANNELS] = '{
        PULSE_W'(LO_RED), PULSE_W'(LO_GREEN), PULSE_W'(LO_BLUE)
    };

    localparam logic [RECIP_W-1:0] RECIP [CHANNELS] = '{
        RECIP_W'(RECIP_RED), RECIP_W'(RECIP_GREEN), RECIP_W'(RECIP_BLUE)
    };

    localparam logic [PULSE_W-1:0] PULSE_TOP_VAL = PULSE_W'(PULSE_TOP);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 8'd255;

    localparam logic [COLOR_W-1:0] RESET_COLORS [REG_COUNT] = '{
        24'd16579579, 24'd7297385, 24'd15965360,
        24'd13034955, 24'd10207200, 24'd15456979
    };

    typedef logic [CHANNELS-1:0][LEVEL_W-1:0] level_vec_t;

    typedef struct packed {
        logic [PULSE_W-1:0] red_pulse_us;
        logic [PULSE_W-1:0] green_pulse_us;
        logic [PULSE_W-1:0] blue_pulse_us;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] match_index;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [DIST_W-1:0]  best_distance;
    } out_item_t;

endpackage

>>> rtl/ncc_level_map.sv
module ncc_level_map (
    input  logic                clk,
    input  logic                en_a,
    input  logic                en_b,
    input  ncc_pkg::in_item_t   item,
    output ncc_pkg::level_vec_t levels
);

    logic [ncc_pkg::CHANNELS-1:0][ncc_pkg::PULSE_W-1:0] pulse;

    assign pulse[0] = item.red_pulse_us;
    assign pulse[1] = item.green_pulse_us;
    assign pulse[2] = item.blue_pulse_us;

    for (genvar c = 0; c < ncc_pkg::CHANNELS; c++)
    begin : g_chan
        logic [ncc_pkg::PULSE_W-1:0]                  offset;
        logic [ncc_pkg::PULSE_W-1:0]                  scaled_next;
        logic [ncc_pkg::PULSE_W-1:0]                  scaled_reg;
        logic                                         sat_hi_reg;
        logic                                         sat_lo_reg;
        logic [ncc_pkg::PULSE_W+ncc_pkg::RECIP_W-1:0] product;
        logic [ncc_pkg::LEVEL_W-1:0]                  quot;
        logic [ncc_pkg::LEVEL_W-1:0]                  level_next;
        logic [ncc_pkg::LEVEL_W-1:0]                  level_reg;

        assign offset      = pulse[c] - ncc_pkg::LO_OFFSET[c];
        assign scaled_next = {offset[ncc_pkg::LEVEL_W-1:0], 8'd0}
                           - {8'd0, offset[ncc_pkg::LEVEL_W-1:0]};

        always_ff @(posedge clk)
        begin
            if (en_a)
            begin
                scaled_reg <= scaled_next;
                sat_hi_reg <= (pulse[c] <= ncc_pkg::LO_OFFSET[c]);
                sat_lo_reg <= (pulse[c] >= ncc_pkg::PULSE_TOP_VAL);
            end
        end

        assign product = scaled_reg * ncc_pkg::RECIP[c];
        assign quot    = product[ncc_pkg::RECIP_SHIFT +: ncc_pkg::LEVEL_W];

        always_comb
        begin
            if (sat_hi_reg)
            begin
                level_next = ncc_pkg::LEVEL_MAX;
            end
            else if (sat_lo_reg)
            begin
                level_next = '0;
            end
            else
            begin
                level_next = ncc_pkg::LEVEL_MAX - quot;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en_b)
            begin
                level_reg <= level_next;
            end
        end

        assign levels[c] = level_reg;
    end

endmodule

>>> rtl/ncc_dist_lane.sv
module ncc_dist_lane (
    input  logic                         clk,
    input  logic                         en,
    input  ncc_pkg::level_vec_t          levels,
    input  logic [ncc_pkg::COLOR_W-1:0]  color,
    output logic [ncc_pkg::DIST_W-1:0]   distance
);

    logic [ncc_pkg::CHANNELS-1:0][ncc_pkg::LEVEL_W-1:0]   ref_lvl;
    logic [ncc_pkg::CHANNELS-1:0][ncc_pkg::LEVEL_W-1:0]   diff;
    logic [ncc_pkg::CHANNELS-1:0][2*ncc_pkg::LEVEL_W-1:0] sq;
    logic [ncc_pkg::DIST_W-1:0]                           distance_next;
    logic [ncc_pkg::DIST_W-1:0]                           distance_reg;

    assign ref_lvl[0] = color[23:16];
    assign ref_lvl[1] = color[15:8];
    assign ref_lvl[2] = color[7:0];

    for (genvar c = 0; c < ncc_pkg::CHANNELS; c++)
    begin : g_sq
        assign diff[c] = (levels[c] > ref_lvl[c]) ? (levels[c] - ref_lvl[c])
                                                  : (ref_lvl[c] - levels[c]);
        assign sq[c]   = diff[c] * diff[c];
    end

    assign distance_next = ncc_pkg::DIST_W'(sq[0]) + ncc_pkg::DIST_W'(sq[1])
                         + ncc_pkg::DIST_W'(sq[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            distance_reg <= distance_next;
        end
    end

    assign distance = distance_reg;

endmodule

>>> rtl/ncc_merge.sv
module ncc_merge #(
    parameter int NUM_REFS = 6
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [ncc_pkg::DIST_W-1:0] distance [NUM_REFS],
    input  ncc_pkg::level_vec_t        levels,
    output ncc_pkg::out_item_t         result
);

    logic [ncc_pkg::DIST_W-1:0]  best_d;
    logic [ncc_pkg::INDEX_W-1:0] best_i;
    ncc_pkg::out_item_t          result_next;
    ncc_pkg::out_item_t          result_reg;

    always_comb
    begin
        best_d = distance[0];
        best_i = '0;
        for (int i = 1; i < NUM_REFS; i++)
        begin
            if (distance[i] < best_d)
            begin
                best_d = distance[i];
                best_i = ncc_pkg::INDEX_W'(i);
            end
        end
    end

    always_comb
    begin
        result_next.match_index   = best_i;
        result_next.red_level     = levels[0];
        result_next.green_level   = levels[1];
        result_next.blue_level    = levels[2];
        result_next.best_distance = best_d;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> rtl/nearest_color_classifier_top.sv
// An accepted input transaction moves through valid registers v1_reg to v4_reg; out_valid is v4_reg.
// Throughput: one transaction per cycle; the pipeline stalls only as far
// back as the first empty stage when out_stall holds the output register.
// Stages: offset and scale, reciprocal multiply, per-color distance lanes,
// minimum merge. Reset clears all valid flags and reloads the reference colors.
module nearest_color_classifier_top #(
    parameter int NUM_REFS = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  ncc_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output ncc_pkg::out_item_t           out_data,
    input  logic                         cfg_wr_en,
    input  logic [ncc_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [ncc_pkg::COLOR_W-1:0]  cfg_data
);

    logic [ncc_pkg::COLOR_W-1:0] color_reg [NUM_REFS];
    logic [ncc_pkg::DIST_W-1:0]  lane_distance [NUM_REFS];
    ncc_pkg::level_vec_t         levels_b;
    ncc_pkg::level_vec_t         levels_c_reg;
    logic                        v1_reg;
    logic                        v2_reg;
    logic                        v3_reg;
    logic                        v4_reg;
    logic                        en1;
    logic                        en2;
    logic                        en3;
    logic                        en4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REFS; i++)
            begin
                color_reg[i] <= ncc_pkg::RESET_COLORS[i];
            end
        end
        else if (cfg_wr_en)
        begin
            for (int i = 0; i < NUM_REFS; i++)
            begin
                if (cfg_index == ncc_pkg::INDEX_W'(i))
                begin
                    color_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign en4 = !v4_reg || !out_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    ncc_level_map u_level_map (
        .clk    (clk),
        .en_a   (en1),
        .en_b   (en2),
        .item   (in_data),
        .levels (levels_b)
    );

    for (genvar k = 0; k < NUM_REFS; k++)
    begin : g_lane
        ncc_dist_lane u_lane (
            .clk      (clk),
            .en       (en3),
            .levels   (levels_b),
            .color    (color_reg[k]),
            .distance (lane_distance[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            levels_c_reg <= levels_b;
        end
    end

    ncc_merge #(
        .NUM_REFS (NUM_REFS)
    ) u_merge (
        .clk      (clk),
        .en       (en4),
        .distance (lane_distance),
        .levels   (levels_c_reg),
        .result   (out_data)
    );

    assign in_stall  = !en1;
    assign out_valid = v4_reg;

endmodule

>>> tb/sv/nearest_color_classifier_top_test.sv
`timescale 1ns / 100ps

class color_match_board;
    localparam int FULL_SCALE = 255;

    logic [ncc_pkg::COLOR_W-1:0] palette [ncc_pkg::REG_COUNT];
    ncc_pkg::out_item_t          pending_matches [$];
    int                          mismatches;
    int                          results_seen;

    function new();
        foreach (palette[i])
            palette[i] = ncc_pkg::RESET_COLORS[i];
        mismatches   = 0;
        results_seen = 0;
    endfunction

    function void set_color(int idx, logic [ncc_pkg::COLOR_W-1:0] value);
        if (idx < ncc_pkg::REG_COUNT)
            palette[idx] = value;
    endfunction

    static function int pulse_level(logic [ncc_pkg::PULSE_W-1:0] pulse, int lo);
        int lvl;
        lvl = (int'(pulse) - lo) * (-FULL_SCALE) / (ncc_pkg::PULSE_TOP - lo) + FULL_SCALE;
        if (lvl < 0)
            lvl = 0;
        if (lvl > FULL_SCALE)
            lvl = FULL_SCALE;
        return lvl;
    endfunction

    function ncc_pkg::out_item_t classify(ncc_pkg::in_item_t s);
        ncc_pkg::out_item_t m;
        int                 lv [3];
        int                 dr, dg, db, sq_sum, best;
        lv[0] = pulse_level(s.red_pulse_us, ncc_pkg::LO_RED);
        lv[1] = pulse_level(s.green_pulse_us, ncc_pkg::LO_GREEN);
        lv[2] = pulse_level(s.blue_pulse_us, ncc_pkg::LO_BLUE);
        best = 0;
        m.match_index = '0;
        for (int i = 0; i < ncc_pkg::REG_COUNT; i++)
        begin
            dr     = lv[0] - int'(palette[i][23:16]);
            dg     = lv[1] - int'(palette[i][15:8]);
            db     = lv[2] - int'(palette[i][7:0]);
            sq_sum = dr * dr + dg * dg + db * db;
            if (i == 0 || sq_sum < best)
            begin
                best          = sq_sum;
                m.match_index = ncc_pkg::INDEX_W'(i);
            end
        end
        m.red_level     = ncc_pkg::LEVEL_W'(lv[0]);
        m.green_level   = ncc_pkg::LEVEL_W'(lv[1]);
        m.blue_level    = ncc_pkg::LEVEL_W'(lv[2]);
        m.best_distance = ncc_pkg::DIST_W'(best);
        return m;
    endfunction

    function void note_sample(ncc_pkg::in_item_t s);
        pending_matches.push_back(classify(s));
    endfunction

    function void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_match(ncc_pkg::out_item_t got);
        ncc_pkg::out_item_t want;
        if (pending_matches.size() == 0)
        begin
            $error("unexpected result transaction: match_index %0d", got.match_index);
            mismatches++;
            return;
        end
        want = pending_matches.pop_front();
        results_seen++;
        check_field("match_index", want.match_index, got.match_index);
        check_field("red_level", want.red_level, got.red_level);
        check_field("green_level", want.green_level, got.green_level);
        check_field("blue_level", want.blue_level, got.blue_level);
        check_field("best_distance", want.best_distance, got.best_distance);
    endfunction
endclass

module nearest_color_classifier_top_test;

    localparam int CYCLE_LIMIT   = 250000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 200;
    localparam int RANDOM_PHASES = 6;
    localparam int CORNER_COUNT  = 20;

    localparam logic [ncc_pkg::PULSE_W-1:0] CORNER_PULSES [CORNER_COUNT][3] = '{
        '{16'd0,     16'd0,     16'd0},
        '{16'd65535, 16'd65535, 16'd65535},
        '{16'd15,    16'd16,    16'd14},
        '{16'd14,    16'd15,    16'd13},
        '{16'd16,    16'd17,    16'd15},
        '{16'd260,   16'd260,   16'd260},
        '{16'd259,   16'd259,   16'd259},
        '{16'd261,   16'd261,   16'd261},
        '{16'd0,     16'd65535, 16'd137},
        '{16'd65535, 16'd0,     16'd260},
        '{16'd137,   16'd138,   16'd136},
        '{16'd100,   16'd200,   16'd50},
        '{16'd250,   16'd20,    16'd140},
        '{16'd1,     16'd2,     16'd3},
        '{16'd32768, 16'd256,   16'd255},
        '{16'd255,   16'd32767, 16'd1},
        '{16'd20,    16'd250,   16'd240},
        '{16'd200,   16'd100,   16'd245},
        '{16'd60,    16'd60,    16'd60},
        '{16'd137,   16'd260,   16'd15}
    };

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    ncc_pkg::in_item_t           in_data   = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    ncc_pkg::out_item_t          out_data;
    logic                        cfg_wr_en = 1'b0;
    logic [ncc_pkg::INDEX_W-1:0] cfg_index = '0;
    logic [ncc_pkg::COLOR_W-1:0] cfg_data  = '0;

    color_match_board board;
    int               cycles         = 0;
    int               tx_burst       = 0;
    int               rx_burst       = 0;
    bit               long_hold_done = 1'b0;

    nearest_color_classifier_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("nearest_color_classifier_top_test: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_match(out_data);
    end

    function automatic int draw_gap(ref int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [ncc_pkg::PULSE_W-1:0] draw_pulse();
        case ($urandom_range(0, 9))
            6, 7:    return ncc_pkg::PULSE_W'($urandom_range(0, 65535));
            8:       return $urandom_range(0, 1) ? '1 : '0;
            9:       return $urandom_range(0, 1) ? ncc_pkg::PULSE_W'($urandom_range(10, 20))
                                                 : ncc_pkg::PULSE_W'($urandom_range(255, 265));
            default: return ncc_pkg::PULSE_W'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic send_sample(ncc_pkg::in_item_t s);
        int gap;
        gap = draw_gap(tx_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (in_stall);
        board.note_sample(s);
    endtask

    task automatic send_pulses(logic [ncc_pkg::PULSE_W-1:0] r,
                               logic [ncc_pkg::PULSE_W-1:0] g,
                               logic [ncc_pkg::PULSE_W-1:0] b);
        ncc_pkg::in_item_t s;
        s.red_pulse_us   = r;
        s.green_pulse_us = g;
        s.blue_pulse_us  = b;
        send_sample(s);
    endtask

    task automatic send_random(int count);
        send_pulses('0, '0, '0);
        send_pulses('1, '1, '1);
        repeat (count)
            send_pulses(draw_pulse(), draw_pulse(), draw_pulse());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_matches.size() > 0)
            @(posedge clk);
    endtask

    task automatic program_colors(logic [ncc_pkg::COLOR_W-1:0] pal [ncc_pkg::REG_COUNT],
                                  bit poke_unused);
        for (int i = 0; i < ncc_pkg::REG_COUNT; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= ncc_pkg::INDEX_W'(i);
            cfg_data  <= pal[i];
            @(posedge clk);
            board.set_color(i, pal[i]);
        end
        if (poke_unused)
        begin
            for (int i = ncc_pkg::REG_COUNT; i < (1 << ncc_pkg::INDEX_W); i++)
            begin
                cfg_wr_en <= 1'b1;
                cfg_index <= ncc_pkg::INDEX_W'(i);
                cfg_data  <= ncc_pkg::COLOR_W'($urandom);
                @(posedge clk);
                board.set_color(i, cfg_data);
            end
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            if (!long_hold_done && board.results_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                gap = HOLD_CYCLES;
            end
            else
                gap = draw_gap(rx_burst);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        logic [ncc_pkg::COLOR_W-1:0] pal [ncc_pkg::REG_COUNT];
        logic [ncc_pkg::COLOR_W-1:0] shade;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < CORNER_COUNT; i++)
            send_pulses(CORNER_PULSES[i][0], CORNER_PULSES[i][1], CORNER_PULSES[i][2]);
        send_random(150);

        for (int ph = 1; ph <= RANDOM_PHASES; ph++)
        begin
            drain();
            shade = ncc_pkg::COLOR_W'($urandom);
            for (int i = 0; i < ncc_pkg::REG_COUNT; i++)
            begin
                case (ph)
                    1:       pal[i] = '0;
                    2:       pal[i] = '1;
                    3:       pal[i] = shade;
                    default:
                        if (i > 0 && $urandom_range(0, 2) == 0)
                            pal[i] = pal[$urandom_range(0, i - 1)];
                        else
                            pal[i] = ncc_pkg::COLOR_W'($urandom);
                endcase
            end
            program_colors(pal, ph == 1 || ph == 4);
            send_random(160);
        end

        drain();
        repeat (8) @(posedge clk);
        if (board.mismatches == 0 && board.pending_matches.size() == 0)
            $display("nearest_color_classifier_top_test: clean");
        else
            $display("nearest_color_classifier_top_test: errors");
        $finish;
    end

endmodule
